@@ hdl/pfps_pkg.sv @@
`timescale 1ns / 1ps

package pfps_pkg;

   localparam int POS_W     = 25;
   localparam int PT_W      = 27;
   localparam int DIFF_W    = 28;
   localparam int SQ_OP_W   = 30;
   localparam int SQ_W      = 60;
   localparam int RAD_W     = 62;
   localparam int ROOT_W    = 31;
   localparam int NUM_W     = 46;
   localparam int DEN_W     = 31;
   localparam int ACC_W     = 48;
   localparam int POT_W     = 40;
   localparam int GAIN_W    = 24;
   localparam int THR_W     = 17;
   localparam int CSR_IDX_W = 3;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 144;

   localparam logic signed [PT_W-1:0] HALF_Q16 = 27'sd32768;
   localparam logic [POT_W-1:0]       POT_MAX  = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd4;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_STEP   = 2'd2,
      ACT_SETPOS = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ACK      = 3'd0,
      ST_POT      = 3'd1,
      ST_MOVED    = 3'd2,
      ST_ARRIVED  = 3'd3,
      ST_DEADLOCK = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PT_QUERY = 3'd0,
      PT_XM    = 3'd1,
      PT_XP    = 3'd2,
      PT_YM    = 3'd3,
      PT_YP    = 3'd4
   } pt_sel_type;

   typedef enum logic [1:0] {
      SQ_GOAL  = 2'd0,
      SQ_CELL  = 2'd1,
      SQ_FORCE = 2'd2
   } sq_src_type;

   typedef enum logic [1:0] {
      DIV_REP = 2'd0,
      DIV_FX  = 2'd1,
      DIV_FY  = 2'd2
   } div_src_type;

   typedef struct packed {
      logic signed [POS_W-1:0] goal_x;
      logic signed [POS_W-1:0] goal_y;
      logic [GAIN_W-1:0]       gain;
      logic [GAIN_W-1:0]       cap;
      logic [THR_W-1:0]        threshold;
   } cfg_type;

   typedef struct packed {
      action_type              action;
      logic [6:0]              cell_x;
      logic [6:0]              cell_y;
      logic                    blocked;
      logic signed [POS_W-1:0] point_x;
      logic signed [POS_W-1:0] point_y;
   } item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] where_x;
      logic signed [POS_W-1:0] where_y;
      logic signed [POS_W-1:0] move_x;
      logic signed [POS_W-1:0] move_y;
      logic [POT_W-1:0]        potential;
   } res_type;

   typedef struct packed {
      logic        load_item;
      logic        clr_wr;
      logic        cell_rd;
      logic        cell_wr;
      logic        eval_load;
      pt_sel_type  pt_sel;
      logic        square;
      sq_src_type  sq_src;
      logic        sqrt_start;
      logic        div_start;
      div_src_type div_src;
      logic        acc_root;
      logic        acc_add;
      logic        scan_init;
      logic        scan_rd;
      logic        scan_adv;
      logic        pot_store;
      logic [1:0]  pot_slot;
      logic        force_form;
      logic        norm_shift;
      logic        mx_store;
      logic        my_store;
      logic        pos_update;
      logic        pos_set;
      logic        rsp_load;
      status_type  rsp_status;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       cell_ok;
      logic       clear_last;
      logic       bit_set;
      logic       scan_last;
      logic       word_end;
      logic       sqrt_done;
      logic       div_done;
      logic       r_zero;
      logic       arrived;
      logic       deadlock;
      logic       norm_big;
   } stat_type;

endpackage

@@ hdl/pfps_sqrt.sv @@
`timescale 1ns / 1ps

// Restoring square root, one result bit per cycle.
module pfps_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pfps_pkg::RAD_W-1:0]     radicand,
   output logic                           done,
   output logic [pfps_pkg::ROOT_W-1:0]    root
);

   localparam int RW = pfps_pkg::ROOT_W;
   localparam int CNT_W = $clog2(RW);

   logic [pfps_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [RW+1:0]              rem_ff, rem_in;
   logic [RW-1:0]              root_ff, root_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [RW+3:0]              rem_sh;
   logic [RW+3:0]              trial;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[pfps_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[pfps_pkg::RAD_W-3:0], 2'b00};
         rem_in  = ge ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
         root_in = {root_ff[RW-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hdl/pfps_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
module pfps_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pfps_pkg::NUM_W-1:0]    numer,
   input  logic [pfps_pkg::DEN_W-1:0]    denom,
   output logic                          done,
   output logic [pfps_pkg::NUM_W-1:0]    quot
);

   localparam int NW = pfps_pkg::NUM_W;
   localparam int DW = pfps_pkg::DEN_W;
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    q_ff, q_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[NW-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         q_in   = {q_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ hdl/pfps_datapath.sv @@
`timescale 1ns / 1ps

module pfps_datapath #(
   parameter int GRID_SIDE = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  pfps_pkg::cmd_type   cmd,
   input  pfps_pkg::item_type  item,
   input  pfps_pkg::cfg_type   cfg,
   output pfps_pkg::stat_type  stat,
   output pfps_pkg::res_type   res
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int WORDS = (CELLS + 63) / 64;
   localparam int AW    = $clog2(WORDS);
   localparam int IW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_SIDE);

   localparam int POS_W  = pfps_pkg::POS_W;
   localparam int PT_W   = pfps_pkg::PT_W;
   localparam int DIFF_W = pfps_pkg::DIFF_W;
   localparam int OP_W   = pfps_pkg::SQ_OP_W;
   localparam int SQ_W   = pfps_pkg::SQ_W;
   localparam int ACC_W  = pfps_pkg::ACC_W;
   localparam int POT_W  = pfps_pkg::POT_W;

   pfps_pkg::item_type item_ff;

   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [POS_W-1:0] wh_x_ff, wh_y_ff;
   logic signed [PT_W-1:0]  ex_ff, ey_ff, ex_in, ey_in;
   logic signed [PT_W-1:0]  px27, py27;

   logic [63:0]    mem [WORDS];
   logic [63:0]    rd_ff;
   logic [63:0]    wr_word;
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_wa, mem_ra;
   logic [63:0]    mem_wd;
   logic [AW-1:0]  clr_ff;
   logic [IW-1:0]  cell_lin;
   logic [AW-1:0]  cell_word;
   logic [IW-1:0]  idx_ff;
   logic [CW-1:0]  cx_ff, cy_ff;

   logic signed [DIFF_W-1:0] dx, dy;
   logic [DIFF_W-1:0]        ndx, ndy;
   logic [OP_W-1:0]          opx, opy;
   logic [SQ_W-1:0]          sq_a_ff, sq_b_ff;

   logic                       sqrt_done;
   logic [pfps_pkg::ROOT_W-1:0] root;
   logic                       div_done;
   logic [pfps_pkg::NUM_W-1:0] quot;
   logic [pfps_pkg::NUM_W-1:0] numer;
   logic [pfps_pkg::DEN_W-1:0] denom;
   logic [pfps_pkg::DEN_W-1:0] norm_den;

   logic [ACC_W-1:0] acc_ff;
   logic [pfps_pkg::GAIN_W-1:0] term;
   logic [POT_W-1:0] pot_sat;
   logic [POT_W-1:0] pot_ff [4];

   logic signed [POT_W:0] fx, fy;
   logic [POT_W:0]        nfx, nfy;
   logic [POT_W-1:0]      ax_ff, ay_ff;
   logic                  fneg_x_ff, fneg_y_ff;
   logic [POT_W-1:0]      thr40;
   logic signed [POS_W-1:0] mx_ff, my_ff;
   logic signed [POS_W:0]   gx, gy, sum_x, sum_y;

   // ---- obstacle memory ----
   assign cell_lin  = IW'(int'(item_ff.cell_y) * GRID_SIDE + int'(item_ff.cell_x));
   assign cell_word = AW'(cell_lin >> 6);

   always_comb begin
      wr_word                = rd_ff;
      wr_word[cell_lin[5:0]] = item_ff.blocked;
   end

   assign mem_we = cmd.clr_wr | cmd.cell_wr;
   assign mem_wa = cmd.clr_wr ? clr_ff : cell_word;
   assign mem_wd = cmd.clr_wr ? 64'd0 : wr_word;
   assign mem_re = cmd.cell_rd | cmd.scan_rd;
   assign mem_ra = cmd.scan_rd ? AW'(idx_ff >> 6) : cell_word;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // ---- scan counters ----
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         idx_ff <= '0;
         cx_ff  <= '0;
         cy_ff  <= '0;
      end else if (cmd.scan_adv) begin
         idx_ff <= idx_ff + 1'b1;
         if (cx_ff == CW'(GRID_SIDE - 1)) begin
            cx_ff <= '0;
            cy_ff <= cy_ff + 1'b1;
         end else begin
            cx_ff <= cx_ff + 1'b1;
         end
      end
   end

   // ---- item, position, evaluation point ----
   assign px27 = {{2{item_ff.point_x[POS_W-1]}}, item_ff.point_x};
   assign py27 = {{2{item_ff.point_y[POS_W-1]}}, item_ff.point_y};

   always_comb begin
      ex_in = {{2{pos_x_ff[POS_W-1]}}, pos_x_ff};
      ey_in = {{2{pos_y_ff[POS_W-1]}}, pos_y_ff};
      unique case (cmd.pt_sel)
         pfps_pkg::PT_QUERY: begin
            ex_in = px27;
            ey_in = py27;
         end
         pfps_pkg::PT_XM: ex_in = ex_in - pfps_pkg::HALF_Q16;
         pfps_pkg::PT_XP: ex_in = ex_in + pfps_pkg::HALF_Q16;
         pfps_pkg::PT_YM: ey_in = ey_in - pfps_pkg::HALF_Q16;
         pfps_pkg::PT_YP: ey_in = ey_in + pfps_pkg::HALF_Q16;
         default: ;
      endcase
   end

   assign sum_x = {pos_x_ff[POS_W-1], pos_x_ff} + {mx_ff[POS_W-1], mx_ff};
   assign sum_y = {pos_y_ff[POS_W-1], pos_y_ff} + {my_ff[POS_W-1], my_ff};

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      if (cmd.pos_set) begin
         pos_x_in = item_ff.point_x;
         pos_y_in = item_ff.point_y;
      end else if (cmd.pos_update) begin
         // saturate to the coordinate range
         pos_x_in = (sum_x[POS_W] != sum_x[POS_W-1])
                  ? {sum_x[POS_W], {(POS_W-1){~sum_x[POS_W]}}} : sum_x[POS_W-1:0];
         pos_y_in = (sum_y[POS_W] != sum_y[POS_W-1])
                  ? {sum_y[POS_W], {(POS_W-1){~sum_y[POS_W]}}} : sum_y[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= item;
         wh_x_ff <= pos_x_ff;
         wh_y_ff <= pos_y_ff;
      end
      if (cmd.eval_load) begin
         ex_ff <= ex_in;
         ey_ff <= ey_in;
      end
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // ---- squares ----
   always_comb begin
      dx = '0;
      dy = '0;
      case (cmd.sq_src)
         pfps_pkg::SQ_GOAL: begin
            dx = DIFF_W'(cfg.goal_x) - DIFF_W'(ex_ff);
            dy = DIFF_W'(cfg.goal_y) - DIFF_W'(ey_ff);
         end
         pfps_pkg::SQ_CELL: begin
            dx = signed'(DIFF_W'({cx_ff, 16'h0000})) - DIFF_W'(ex_ff);
            dy = signed'(DIFF_W'({cy_ff, 16'h0000})) - DIFF_W'(ey_ff);
         end
         default: ;
      endcase
      ndx = -dx;
      ndy = -dy;
      if (cmd.sq_src == pfps_pkg::SQ_FORCE) begin
         opx = ax_ff[OP_W-1:0];
         opy = ay_ff[OP_W-1:0];
      end else begin
         opx = OP_W'(dx[DIFF_W-1] ? ndx : dx);
         opy = OP_W'(dy[DIFF_W-1] ? ndy : dy);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_a_ff <= opx * opx;
         sq_b_ff <= opy * opy;
      end
   end

   pfps_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (pfps_pkg::RAD_W'(sq_a_ff) + pfps_pkg::RAD_W'(sq_b_ff)),
      .done     (sqrt_done),
      .root     (root)
   );

   // ---- division ----
   assign norm_den = (root == '0) ? pfps_pkg::DEN_W'(1) : root;

   always_comb begin
      numer = {6'b0, cfg.gain, 16'h0000};
      denom = root;
      case (cmd.div_src)
         pfps_pkg::DIV_FX: begin
            numer = {ax_ff[OP_W-1:0], 16'h0000};
            denom = norm_den;
         end
         pfps_pkg::DIV_FY: begin
            numer = {ay_ff[OP_W-1:0], 16'h0000};
            denom = norm_den;
         end
         default: ;
      endcase
   end

   pfps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (denom),
      .done  (div_done),
      .quot  (quot)
   );

   // ---- potential accumulation ----
   always_comb begin
      if (root == '0 || quot > pfps_pkg::NUM_W'(cfg.cap)) begin
         term = cfg.cap;
      end else begin
         term = quot[pfps_pkg::GAIN_W-1:0];
      end
   end

   assign pot_sat = (acc_ff > ACC_W'(pfps_pkg::POT_MAX)) ? pfps_pkg::POT_MAX
                                                          : acc_ff[POT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.acc_root) begin
         acc_ff <= ACC_W'(root);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + ACC_W'(term);
      end
      if (cmd.pot_store) pot_ff[cmd.pot_slot] <= pot_sat;
   end

   // ---- force and normalization ----
   assign fx  = signed'({1'b0, pot_ff[0]}) - signed'({1'b0, pot_ff[1]});
   assign fy  = signed'({1'b0, pot_ff[2]}) - signed'({1'b0, pot_ff[3]});
   assign nfx = -fx;
   assign nfy = -fy;

   always_ff @(posedge clock) begin
      if (cmd.force_form) begin
         fneg_x_ff <= fx[POT_W];
         fneg_y_ff <= fy[POT_W];
         ax_ff     <= fx[POT_W] ? nfx[POT_W-1:0] : fx[POT_W-1:0];
         ay_ff     <= fy[POT_W] ? nfy[POT_W-1:0] : fy[POT_W-1:0];
      end else if (cmd.norm_shift) begin
         ax_ff <= ax_ff >> 1;
         ay_ff <= ay_ff >> 1;
      end
      if (cmd.mx_store) begin
         mx_ff <= fneg_x_ff ? -quot[POS_W-1:0] : quot[POS_W-1:0];
      end
      if (cmd.my_store) begin
         my_ff <= fneg_y_ff ? -quot[POS_W-1:0] : quot[POS_W-1:0];
      end
   end

   assign thr40 = POT_W'(cfg.threshold);

   // ---- status ----
   assign gx = {cfg.goal_x[POS_W-1], cfg.goal_x} - {pos_x_ff[POS_W-1], pos_x_ff};
   assign gy = {cfg.goal_y[POS_W-1], cfg.goal_y} - {pos_y_ff[POS_W-1], pos_y_ff};

   always_comb begin
      stat.action     = item_ff.action;
      stat.cell_ok    = (int'(item_ff.cell_x) < GRID_SIDE) &&
                        (int'(item_ff.cell_y) < GRID_SIDE);
      stat.clear_last = (clr_ff == AW'(WORDS - 1));
      stat.bit_set    = rd_ff[idx_ff[5:0]];
      stat.scan_last  = (idx_ff == IW'(CELLS - 1));
      stat.word_end   = (idx_ff[5:0] == 6'h3f);
      stat.sqrt_done  = sqrt_done;
      stat.div_done   = div_done;
      stat.r_zero     = (root == '0);
      stat.arrived    = (gx > -26'sd65536) && (gx < 26'sd65536) &&
                        (gy > -26'sd65536) && (gy < 26'sd65536);
      stat.deadlock   = ((ax_ff < thr40) && (ay_ff < thr40)) ||
                        ((ax_ff == '0) && (ay_ff == '0));
      stat.norm_big   = |(ax_ff[POT_W-1:OP_W] | ay_ff[POT_W-1:OP_W]);
   end

   // ---- result fields ----
   always_comb begin
      res = '0;
      unique case (cmd.rsp_status)
         pfps_pkg::ST_POT: begin
            res.where_x   = item_ff.point_x;
            res.where_y   = item_ff.point_y;
            res.potential = pot_ff[0];
         end
         pfps_pkg::ST_MOVED: begin
            res.where_x = wh_x_ff;
            res.where_y = wh_y_ff;
            res.move_x  = mx_ff;
            res.move_y  = my_ff;
         end
         pfps_pkg::ST_ARRIVED: begin
            res.where_x = wh_x_ff;
            res.where_y = wh_y_ff;
            res.move_x  = gx[POS_W-1:0];
            res.move_y  = gy[POS_W-1:0];
         end
         pfps_pkg::ST_DEADLOCK: begin
            res.where_x = wh_x_ff;
            res.where_y = wh_y_ff;
         end
         default: ;
      endcase
   end

endmodule

@@ hdl/pfps_ctrl.sv @@
`timescale 1ns / 1ps

module pfps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                out_free,
   input  pfps_pkg::stat_type  stat,
   output pfps_pkg::cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_CELL_RD, S_CELL_WR,
      S_G_SQ, S_G_RT, S_G_WAIT, S_RD, S_BIT,
      S_C_SQ, S_C_RT, S_C_WAIT, S_C_DIV, S_D_WAIT, S_NEXT, S_END,
      S_F_FORM, S_F_CHK, S_F_NORM, S_F_SQ, S_F_RT, S_F_WAIT,
      S_DX, S_DX_WAIT, S_DY, S_DY_WAIT, S_MOVE, S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   pfps_pkg::status_type st_ff, st_in;

   function automatic pfps_pkg::pt_sel_type probe(input logic [1:0] ph);
      pfps_pkg::pt_sel_type sel;
      unique case (ph)
         2'd0:    sel = pfps_pkg::PT_XM;
         2'd1:    sel = pfps_pkg::PT_XP;
         2'd2:    sel = pfps_pkg::PT_YM;
         default: sel = pfps_pkg::PT_YP;
      endcase
      return sel;
   endfunction

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.sq_src = pfps_pkg::SQ_GOAL;
      state_in   = state_ff;
      phase_in   = phase_ff;
      st_in      = st_ff;
      cmd.rsp_status = st_ff;
      cmd.pot_slot   = phase_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            phase_in = 2'd0;
            unique case (stat.action)
               pfps_pkg::ACT_WRITE: begin
                  st_in    = pfps_pkg::ST_ACK;
                  state_in = stat.cell_ok ? S_CELL_RD : S_FINISH;
               end
               pfps_pkg::ACT_QUERY: begin
                  st_in         = pfps_pkg::ST_POT;
                  cmd.eval_load = 1'b1;
                  cmd.pt_sel    = pfps_pkg::PT_QUERY;
                  state_in      = S_G_SQ;
               end
               pfps_pkg::ACT_STEP: begin
                  if (stat.arrived) begin
                     st_in    = pfps_pkg::ST_ARRIVED;
                     state_in = S_FINISH;
                  end else begin
                     st_in         = pfps_pkg::ST_MOVED;
                     cmd.eval_load = 1'b1;
                     cmd.pt_sel    = probe(2'd0);
                     state_in      = S_G_SQ;
                  end
               end
               default: begin
                  st_in       = pfps_pkg::ST_ACK;
                  cmd.pos_set = 1'b1;
                  state_in    = S_FINISH;
               end
            endcase
         end
         S_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_CELL_WR;
         end
         S_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            state_in    = S_FINISH;
         end
         S_G_SQ: begin
            cmd.square = 1'b1;
            cmd.sq_src = pfps_pkg::SQ_GOAL;
            state_in   = S_G_RT;
         end
         S_G_RT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_G_WAIT;
         end
         S_G_WAIT: begin
            if (stat.sqrt_done) begin
               cmd.acc_root  = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_BIT;
         end
         S_BIT: begin
            if (stat.bit_set) begin
               state_in = S_C_SQ;
            end else if (stat.scan_last) begin
               state_in = S_END;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = stat.word_end ? S_RD : S_BIT;
            end
         end
         S_C_SQ: begin
            cmd.square = 1'b1;
            cmd.sq_src = pfps_pkg::SQ_CELL;
            state_in   = S_C_RT;
         end
         S_C_RT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_C_WAIT;
         end
         S_C_WAIT: begin
            if (stat.sqrt_done) state_in = S_C_DIV;
         end
         S_C_DIV: begin
            if (stat.r_zero) begin
               cmd.acc_add = 1'b1;
               state_in    = S_NEXT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = pfps_pkg::DIV_REP;
               state_in      = S_D_WAIT;
            end
         end
         S_D_WAIT: begin
            if (stat.div_done) begin
               cmd.acc_add = 1'b1;
               state_in    = S_NEXT;
            end
         end
         S_NEXT: begin
            if (stat.scan_last) begin
               state_in = S_END;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = stat.word_end ? S_RD : S_BIT;
            end
         end
         S_END: begin
            cmd.pot_store = 1'b1;
            if (st_ff == pfps_pkg::ST_POT) begin
               state_in = S_FINISH;
            end else if (phase_ff != 2'd3) begin
               phase_in      = phase_ff + 1'b1;
               cmd.eval_load = 1'b1;
               cmd.pt_sel    = probe(phase_ff + 1'b1);
               state_in      = S_G_SQ;
            end else begin
               state_in = S_F_FORM;
            end
         end
         S_F_FORM: begin
            cmd.force_form = 1'b1;
            state_in       = S_F_CHK;
         end
         S_F_CHK: begin
            if (stat.deadlock) begin
               st_in    = pfps_pkg::ST_DEADLOCK;
               state_in = S_FINISH;
            end else begin
               state_in = S_F_NORM;
            end
         end
         S_F_NORM: begin
            if (stat.norm_big) cmd.norm_shift = 1'b1;
            else state_in = S_F_SQ;
         end
         S_F_SQ: begin
            cmd.square = 1'b1;
            cmd.sq_src = pfps_pkg::SQ_FORCE;
            state_in   = S_F_RT;
         end
         S_F_RT: begin
            cmd.sqrt_start = 1'b1;
            state_in       = S_F_WAIT;
         end
         S_F_WAIT: begin
            if (stat.sqrt_done) state_in = S_DX;
         end
         S_DX: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = pfps_pkg::DIV_FX;
            state_in      = S_DX_WAIT;
         end
         S_DX_WAIT: begin
            if (stat.div_done) begin
               cmd.mx_store = 1'b1;
               state_in     = S_DY;
            end
         end
         S_DY: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = pfps_pkg::DIV_FY;
            state_in      = S_DY_WAIT;
         end
         S_DY_WAIT: begin
            if (stat.div_done) begin
               cmd.my_store = 1'b1;
               state_in     = S_MOVE;
            end
         end
         S_MOVE: begin
            cmd.pos_update = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         phase_ff <= 2'd0;
         st_ff    <= pfps_pkg::ST_ACK;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         st_ff    <= st_in;
      end
   end

endmodule

@@ hdl/potential_field_path_step.sv @@
// Potential-field path planner: keeps a GRID_SIDE x GRID_SIDE obstacle bitmap and a current
// position, and per request item writes a cell, evaluates the potential at a point, takes
// one path step, or sets the position; every item yields exactly one response transfer.
// After reset a clearing pass zeroes the bitmap one 64-cell word per cycle
// (GRID_SIDE*GRID_SIDE/64 words, 256 at the default size) while req_tready stays low.
// One item is in work at a time. A potential evaluation scans every cell, one clear
// cell per cycle plus one memory read per 64 cells, and each blocked cell adds a
// bit-serial square root and, unless its distance is zero, a bit-serial divide. A
// step that has not yet arrived runs four such scans, then, unless deadlocked, a
// square root and two divides for the move. A single shared root unit and a single
// divide unit serve all of this work. A finished response is held in an output
// register, so the next request is taken while it waits. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module potential_field_path_step #(
   parameter int GRID_SIDE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: tdata = cell_x[6:0], cell_y[13:7], blocked[14], point_x[39:15],
   //          point_y[64:40], zero fill to 72 bits
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pfps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,    // action[1:0]
   // response: tdata = where_x[24:0], where_y[49:25], move_x[74:50], move_y[99:75],
   //           potential[139:100], zero fill to 144 bits
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pfps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [2:0]                          rsp_tuser,    // status[2:0]
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfps_pkg::POS_W-1:0]          csr_data
);

   pfps_pkg::cfg_type  cfg_ff;
   pfps_pkg::item_type item;
   pfps_pkg::cmd_type  cmd;
   pfps_pkg::stat_type stat;
   pfps_pkg::res_type  res;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [pfps_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic [2:0]                         rsp_user_ff;
   logic                               out_free;

   // Register writes are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.goal_x    <= 25'sd5898240;   // 90.0
         cfg_ff.goal_y    <= 25'sd3276800;   // 50.0
         cfg_ff.gain      <= 24'd196608;     // 3.0
         cfg_ff.cap       <= 24'd6553600;    // 100.0
         cfg_ff.threshold <= 17'd655;        // about 0.01
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pfps_pkg::CSR_GOAL_X:    cfg_ff.goal_x    <= csr_data;
            pfps_pkg::CSR_GOAL_Y:    cfg_ff.goal_y    <= csr_data;
            pfps_pkg::CSR_GAIN:      cfg_ff.gain      <= csr_data[pfps_pkg::GAIN_W-1:0];
            pfps_pkg::CSR_CAP:       cfg_ff.cap       <= csr_data[pfps_pkg::GAIN_W-1:0];
            pfps_pkg::CSR_THRESHOLD: cfg_ff.threshold <= csr_data[pfps_pkg::THR_W-1:0];
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // Unpack the request transfer.
   assign item.action  = pfps_pkg::action_type'(req_tuser);
   assign item.cell_x  = req_tdata[6:0];
   assign item.cell_y  = req_tdata[13:7];
   assign item.blocked = req_tdata[14];
   assign item.point_x = req_tdata[39:15];
   assign item.point_y = req_tdata[64:40];

   // The output register may be refilled when empty or when its transfer completes now.
   assign out_free = !rsp_valid_ff || rsp_tready;

   pfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   pfps_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .item  (item),
      .cfg   (cfg_ff),
      .stat  (stat),
      .res   (res)
   );

   // Output register: hold the result until its transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {4'h0, res.potential, res.move_y, res.move_x,
                         res.where_y, res.where_x};
         rsp_user_ff <= cmd.rsp_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A new result never overwrites one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response register overwritten");

   // One item at a time: the request side closes right after a transfer.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // The clearing pass runs first after reset.
   a_clear_first: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request side open during clearing pass");

endmodule

@@ verif/pfps_checker.sv @@
`timescale 1ns / 1ps

module pfps_checker #(
   parameter int GRID_SIDE = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [pfps_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [pfps_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic [2:0]                          rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pfps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfps_pkg::POS_W-1:0]          csr_data,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int POS_W = pfps_pkg::POS_W;
   localparam int POT_W = pfps_pkg::POT_W;

   localparam longint POS_HI = 64'sd16777215;
   localparam longint POS_LO = -64'sd16777216;
   localparam longint ONE    = 64'sd65536;
   localparam longint HALF   = 64'sd32768;
   localparam longint unsigned POT_CEIL = 64'hFF_FFFF_FFFF;

   typedef struct {
      pfps_pkg::status_type    status;
      logic signed [POS_W-1:0] where_x, where_y, move_x, move_y;
      logic [POT_W-1:0]        potential;
   } outcome_type;

   outcome_type outcome_q[$];

   bit      blocked_cells[GRID_SIDE*GRID_SIDE];
   longint  pos_x, pos_y, goal_x, goal_y;
   longint unsigned gain, cap, threshold;

   assign pending = outcome_q.size();

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned span(longint dx, longint dy);
      longint unsigned ax, ay;
      ax = mag(dx);
      ay = mag(dy);
      return root_floor(ax * ax + ay * ay);
   endfunction

   // goal attraction plus capped repulsion of every blocked cell, saturated to 40 bits
   function automatic longint unsigned field_at(longint x, longint y);
      longint unsigned sum, r, t;
      sum = span(goal_x - x, goal_y - y);
      for (int cy = 0; cy < GRID_SIDE; cy++)
         for (int cx = 0; cx < GRID_SIDE; cx++) begin
            if (!blocked_cells[cy*GRID_SIDE + cx]) continue;
            r = span(longint'(cx) * ONE - x, longint'(cy) * ONE - y);
            if (r == 0) t = cap;
            else begin
               t = (gain << 16) / r;
               if (t > cap) t = cap;
            end
            sum += t;
         end
      return (sum > POT_CEIL) ? POT_CEIL : sum;
   endfunction

   function automatic longint clamp_pos(longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   function automatic outcome_type plan(pfps_pkg::action_type act, int cx, int cy, bit blk,
                                        longint px, longint py);
      outcome_type o;
      longint gx, gy, fx, fy, mx, my;
      longint unsigned ax, ay, n, ux, uy, pot;
      o = '{pfps_pkg::ST_ACK, '0, '0, '0, '0, '0};
      case (act)
         pfps_pkg::ACT_WRITE: begin
            if (cx < GRID_SIDE && cy < GRID_SIDE) blocked_cells[cy*GRID_SIDE + cx] = blk;
         end
         pfps_pkg::ACT_QUERY: begin
            o.status    = pfps_pkg::ST_POT;
            o.where_x   = px[POS_W-1:0];
            o.where_y   = py[POS_W-1:0];
            pot         = field_at(px, py);
            o.potential = pot[POT_W-1:0];
         end
         pfps_pkg::ACT_SETPOS: begin
            pos_x = px;
            pos_y = py;
         end
         default: begin
            gx = goal_x - pos_x;
            gy = goal_y - pos_y;
            o.where_x = pos_x[POS_W-1:0];
            o.where_y = pos_y[POS_W-1:0];
            if (mag(gx) < ONE && mag(gy) < ONE) begin
               o.status = pfps_pkg::ST_ARRIVED;
               o.move_x = gx[POS_W-1:0];
               o.move_y = gy[POS_W-1:0];
            end else begin
               fx = longint'(field_at(pos_x - HALF, pos_y)) -
                    longint'(field_at(pos_x + HALF, pos_y));
               fy = longint'(field_at(pos_x, pos_y - HALF)) -
                    longint'(field_at(pos_x, pos_y + HALF));
               ax = mag(fx);
               ay = mag(fy);
               if ((ax < threshold && ay < threshold) || (ax == 0 && ay == 0)) begin
                  o.status = pfps_pkg::ST_DEADLOCK;
               end else begin
                  // shrink both together until the squares fit
                  while ((ax | ay) >= (64'd1 << 30)) begin
                     ax >>= 1;
                     ay >>= 1;
                  end
                  n = root_floor(ax * ax + ay * ay);
                  if (n == 0) n = 1;
                  ux = (ax << 16) / n;
                  uy = (ay << 16) / n;
                  mx = (fx < 0) ? -longint'(ux) : longint'(ux);
                  my = (fy < 0) ? -longint'(uy) : longint'(uy);
                  o.status = pfps_pkg::ST_MOVED;
                  o.move_x = mx[POS_W-1:0];
                  o.move_y = my[POS_W-1:0];
                  pos_x = clamp_pos(pos_x + mx);
                  pos_y = clamp_pos(pos_y + my);
               end
            end
         end
      endcase
      return o;
   endfunction

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] %s mismatch: got %h, want %h", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      outcome_type want;
      logic signed [POS_W-1:0] in_px, in_py;
      if (reset) begin
         blocked_cells = '{default: 1'b0};
         pos_x     = 0;
         pos_y     = 0;
         goal_x    = 5898240;
         goal_y    = 3276800;
         gain      = 196608;
         cap       = 6553600;
         threshold = 655;
         outcome_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pfps_pkg::CSR_GOAL_X:    goal_x    = longint'($signed(csr_data));
               pfps_pkg::CSR_GOAL_Y:    goal_y    = longint'($signed(csr_data));
               pfps_pkg::CSR_GAIN:      gain      = 64'(csr_data[pfps_pkg::GAIN_W-1:0]);
               pfps_pkg::CSR_CAP:       cap       = 64'(csr_data[pfps_pkg::GAIN_W-1:0]);
               pfps_pkg::CSR_THRESHOLD: threshold = 64'(csr_data[pfps_pkg::THR_W-1:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            in_px = req_tdata[39:15];
            in_py = req_tdata[64:40];
            outcome_q.push_back(plan(pfps_pkg::action_type'(req_tuser),
                                     int'(req_tdata[6:0]), int'(req_tdata[13:7]),
                                     req_tdata[14], longint'(in_px), longint'(in_py)));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               report("unexpected transfer", 64'(rsp_tuser), 0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tuser !== want.status)
                  report("status", 64'(rsp_tuser), 64'(want.status));
               if (rsp_tdata[24:0] !== want.where_x)
                  report("where_x", 64'(rsp_tdata[24:0]), 64'(want.where_x));
               if (rsp_tdata[49:25] !== want.where_y)
                  report("where_y", 64'(rsp_tdata[49:25]), 64'(want.where_y));
               if (rsp_tdata[74:50] !== want.move_x)
                  report("move_x", 64'(rsp_tdata[74:50]), 64'(want.move_x));
               if (rsp_tdata[99:75] !== want.move_y)
                  report("move_y", 64'(rsp_tdata[99:75]), 64'(want.move_y));
               if (rsp_tdata[139:100] !== want.potential)
                  report("potential", 64'(rsp_tdata[139:100]), 64'(want.potential));
            end
         end
      end
   end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

   localparam int  UNIT   = 65536;
   localparam int  POS_HI = 16777215;
   localparam int  POS_LO = -16777216;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [pfps_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic [1:0]                          req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [pfps_pkg::RSP_DATA_W-1:0]     rsp_tdata;
   logic [2:0]                          rsp_tuser;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [pfps_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [pfps_pkg::POS_W-1:0]          csr_data;

   int  fail_count;
   int  pending;
   bit  steady;      // suppress random idling on both sides
   int  hold_left;   // cycles the receiver still holds off

   potential_field_path_step DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   pfps_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #(64'd2_000_000_000);
      $display("testbench: errors");
      $finish;
   end

   // receiver: random back-pressure, plus a long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 29);
         end
      end
   end

   // offer one request and hold it until the transfer; idle afterwards at random
   task automatic send(pfps_pkg::action_type act, int cx, int cy, bit blk, int px, int py);
      logic signed [pfps_pkg::POS_W-1:0] sx, sy;
      sx = px[pfps_pkg::POS_W-1:0];
      sy = py[pfps_pkg::POS_W-1:0];
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'b0, sy, sx, blk, cy[6:0], cx[6:0]};
      do @(posedge clock); while (!req_tready);
      if (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [pfps_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[pfps_pkg::POS_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // drop valid and let every outstanding response drain before touching registers
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int near_coord();
      return $urandom_range(30 * UNIT);
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(POS_HI - POS_LO)) + POS_LO;
   endfunction

   task automatic random_item();
      int pick, cx, cy;
      pick = $urandom_range(99);
      if (pick < 35) begin
         // keep the obstacle field small, but touch every column and row bit now and then
         if ($urandom_range(9) == 0) begin
            cx = $urandom_range(127);
            cy = $urandom_range(127);
         end else begin
            cx = $urandom_range(7);
            cy = $urandom_range(7);
         end
         send(pfps_pkg::ACT_WRITE, cx, cy, $urandom_range(99) < 40, any_coord(), any_coord());
      end else if (pick < 60) begin
         if ($urandom_range(6) == 0)
            send(pfps_pkg::ACT_SETPOS, 0, 0, 0, any_coord(), any_coord());
         else send(pfps_pkg::ACT_SETPOS, $urandom_range(127), $urandom_range(127), 1,
                   near_coord(), near_coord());
      end else if (pick < 83) begin
         if ($urandom_range(4) == 0)
            send(pfps_pkg::ACT_QUERY, 0, 0, 0, any_coord(), any_coord());
         else send(pfps_pkg::ACT_QUERY, 0, 0, 0, near_coord(), near_coord());
      end else begin
         send(pfps_pkg::ACT_STEP, $urandom_range(127), $urandom_range(127), $urandom_range(1),
              any_coord(), any_coord());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = pfps_pkg::ACT_WRITE;
      csr_valid  = 1'b0;
      csr_index  = pfps_pkg::CSR_GOAL_X;
      csr_data   = '0;
      steady     = 1'b0;
      hold_left  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // obstacles at both corners, clear one again
      send(pfps_pkg::ACT_WRITE, 0, 0, 1, 0, 0);
      send(pfps_pkg::ACT_WRITE, 127, 127, 1, 0, 0);
      send(pfps_pkg::ACT_WRITE, 127, 127, 0, 0, 0);
      send(pfps_pkg::ACT_WRITE, 3, 4, 1, POS_HI, POS_LO);
      // queries at the coordinate extremes, on an obstacle and beside one
      send(pfps_pkg::ACT_QUERY, 0, 0, 0, POS_HI, POS_HI);
      send(pfps_pkg::ACT_QUERY, 0, 0, 0, POS_LO, POS_LO);
      send(pfps_pkg::ACT_QUERY, 0, 0, 0, 0, 0);
      send(pfps_pkg::ACT_QUERY, 0, 0, 0, 3 * UNIT + UNIT / 2, 4 * UNIT);
      // half a unit from the goal: arrival
      send(pfps_pkg::ACT_SETPOS, 0, 0, 0, 89 * UNIT + UNIT / 2, 49 * UNIT + UNIT / 2);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      // ordinary moves
      send(pfps_pkg::ACT_SETPOS, 0, 0, 0, 10 * UNIT, 10 * UNIT);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      drain();

      // threshold raised to 65536: diagonal pull stays under it, so deadlock
      write_reg(pfps_pkg::CSR_THRESHOLD, 65536);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      drain();

      // extreme goal, gain and cap, zero threshold
      write_reg(pfps_pkg::CSR_GOAL_X, POS_LO);
      write_reg(pfps_pkg::CSR_GOAL_Y, POS_HI);
      write_reg(pfps_pkg::CSR_GAIN, 24'hFFFFFF);
      write_reg(pfps_pkg::CSR_CAP, 24'hFFFFFF);
      write_reg(pfps_pkg::CSR_THRESHOLD, 0);
      send(pfps_pkg::ACT_SETPOS, 0, 0, 0, POS_LO, POS_HI);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      send(pfps_pkg::ACT_SETPOS, 0, 0, 0, UNIT / 2, 0);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      send(pfps_pkg::ACT_QUERY, 0, 0, 0, 3 * UNIT, 4 * UNIT);
      drain();

      // no repulsion at all
      write_reg(pfps_pkg::CSR_GAIN, 0);
      write_reg(pfps_pkg::CSR_CAP, 0);
      write_reg(pfps_pkg::CSR_GOAL_X, 20 * UNIT);
      write_reg(pfps_pkg::CSR_GOAL_Y, 0);
      send(pfps_pkg::ACT_SETPOS, 0, 0, 0, 5 * UNIT, 7 * UNIT);
      send(pfps_pkg::ACT_STEP, 0, 0, 0, 0, 0);
      drain();

      // random part, first with the default-like setting and a long receiver hold-off
      write_reg(pfps_pkg::CSR_GOAL_X, 5898240);
      write_reg(pfps_pkg::CSR_GOAL_Y, 3276800);
      write_reg(pfps_pkg::CSR_GAIN, 196608);
      write_reg(pfps_pkg::CSR_CAP, 6553600);
      write_reg(pfps_pkg::CSR_THRESHOLD, 655);
      hold_left = 400;
      for (int i = 0; i < 50; i++) begin
         steady = (i >= 20 && i < 32);
         random_item();
      end
      steady = 1'b0;
      drain();

      // then with random goal near the grid and random gains
      write_reg(pfps_pkg::CSR_GOAL_X, near_coord());
      write_reg(pfps_pkg::CSR_GOAL_Y, near_coord());
      write_reg(pfps_pkg::CSR_GAIN, $urandom_range(24'hFFFFFF));
      write_reg(pfps_pkg::CSR_CAP, $urandom_range(24'hFFFFFF));
      write_reg(pfps_pkg::CSR_THRESHOLD, $urandom_range(2000));
      for (int i = 0; i < 50; i++) random_item();
      drain();
      repeat (100) @(posedge clock);

      if (fail_count == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
